// ===== hdl/sdss_pkg.sv =====
`default_nettype none
package sdss_pkg;

  // Number of cells in the sorting chain. This is the list capacity.
  localparam int MAX_ENTRIES = 64;

  localparam int TAG_W   = 32;
  localparam int SCORE_W = 32;

  typedef struct packed {
    logic [TAG_W-1:0]          item_tag;
    logic signed [SCORE_W-1:0] item_score;
    logic                      end_of_list;
  } item_req_t;

  typedef struct packed {
    logic [TAG_W-1:0]          sorted_tag;
    logic signed [SCORE_W-1:0] sorted_score;
    logic                      final_result;
    logic                      overflowed;
  } result_req_t;

  // Contents of one cell of the chain.
  typedef struct packed {
    logic                      valid;
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic                      insert;
    logic                      shift_up;
    logic [TAG_W-1:0]          new_tag;
    logic signed [SCORE_W-1:0] new_score;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hdl/stable_descending_score_sorter.sv =====
`default_nettype none
// Stable descending score sorter. Requests of (tag, signed score) are loaded
// one per cycle into a chain of MAX_ENTRIES cells; every cell compares the
// incoming score with its own entry in the same cycle, and the entries below
// the insertion point move down by one cell, so the chain is always sorted by
// descending score with equal scores in arrival order. When the request marked
// end_of_list has been taken, the block stops taking requests and emits the
// held list from the head of the chain, one result per cycle while the result
// side does not stall, with final_result on the last one; item_stall stays
// high throughout the emission. Requests that arrive while all cells are
// full are dropped and overflowed is set on every result of that list. After
// the last result is taken out of the chain, the block is empty and ready
// for the next list.
module stable_descending_score_sorter (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  sdss_pkg::item_req_t    item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output sdss_pkg::result_req_t  result
);
  import sdss_pkg::*;

  entry_t                   entries [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]   places;
  logic [MAX_ENTRIES-1:0]   valid_vec;
  cell_ctrl_t               ctrl;

  logic draining;
  logic drop_flag;
  logic ovf_latched;

  logic item_accept;
  logic full;
  logic take;
  logic last_entry;

  // The chain fills from cell zero, so the last cell being valid means full.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      valid_vec[i] = entries[i].valid;
    end
  end

  assign full        = entries[MAX_ENTRIES-1].valid;
  assign item_stall  = draining;
  assign item_accept = item_valid && !item_stall;

  // During emission the head entry moves to the result register whenever
  // that register is empty or being emptied in this cycle.
  assign take       = draining && (!result_valid || !result_stall);
  assign last_entry = !entries[1].valid;

  always_comb begin
    ctrl.insert    = item_accept && !full;
    ctrl.shift_up  = take;
    ctrl.new_tag   = item.item_tag;
    ctrl.new_score = item.item_score;
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_p;

    if (i == 0) begin : g_head
      assign prev_e = entry_t'('0);
      assign prev_p = 1'b0;
    end else begin : g_body
      assign prev_e = entries[i-1];
      assign prev_p = places[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign next_e = entry_t'('0);
    end else begin : g_link
      assign next_e = entries[i+1];
    end

    sdss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_entry (prev_e),
      .prev_place (prev_p),
      .next_entry (next_e),
      .entry      (entries[i]),
      .place      (places[i])
    );
  end

  // List control: the drop flag collects overflow while loading, and is
  // handed to the emission when the end of the list is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      draining    <= 1'b0;
      drop_flag   <= 1'b0;
      ovf_latched <= 1'b0;
    end else begin
      if (item_accept) begin
        if (item.end_of_list) begin
          draining    <= 1'b1;
          ovf_latched <= drop_flag || full;
          drop_flag   <= 1'b0;
        end else if (full) begin
          drop_flag <= 1'b1;
        end
      end
      if (take && last_entry) begin
        draining <= 1'b0;
      end
    end
  end

  // Result register parts the chain from the result side.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.sorted_tag   <= entries[0].tag;
      result.sorted_score <= entries[0].score;
      result.final_result <= last_entry;
      result.overflowed   <= ovf_latched;
    end
  end

  // Valid cells always form an unbroken run starting at cell zero.
  assert property (@(posedge clk) disable iff (rst)
    ((valid_vec & (valid_vec + 1'b1)) == '0))
    else $error("sorter chain holds a gap between valid cells");

  // While emitting, the head cell always holds an entry.
  assert property (@(posedge clk) disable iff (rst)
    draining |-> entries[0].valid)
    else $error("sorter emitting from an empty chain");

  // Taking the end of a list always starts an emission.
  assert property (@(posedge clk) disable iff (rst)
    (item_accept && item.end_of_list) |=> draining)
    else $error("end of list did not start emission");

  // A result that leaves the chain as the last one ends the emission.
  assert property (@(posedge clk) disable iff (rst)
    (take && last_entry) |=> (!draining && result_valid && result.final_result))
    else $error("final result did not close the emission");

endmodule
`default_nettype wire

// ===== hdl/sdss_cell.sv =====
`default_nettype none
module sdss_cell (
  input  logic               clk,
  input  logic               rst,
  input  sdss_pkg::cell_ctrl_t ctrl,
  input  sdss_pkg::entry_t   prev_entry,
  input  logic               prev_place,
  input  sdss_pkg::entry_t   next_entry,
  output sdss_pkg::entry_t   entry,
  output logic               place
);
  import sdss_pkg::*;

  entry_t entry_next;

  // The new item belongs at or above this cell when the cell is empty or
  // holds a strictly lower score, so equal scores keep arrival order.
  always_comb begin
    place = !entry.valid || ($signed(ctrl.new_score) > $signed(entry.score));
  end

  always_comb begin
    entry_next = entry;
    if (ctrl.shift_up) begin
      entry_next = next_entry;
    end else if (ctrl.insert && place) begin
      if (prev_place) begin
        entry_next = prev_entry;
      end else begin
        entry_next = entry_t'{valid: 1'b1, tag: ctrl.new_tag, score: ctrl.new_score};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule
`default_nettype wire
